// ===== sv/lrufr_pkg.sv =====
package lrufr_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int FRAME_W    = 6;
    localparam int CFG_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W      = (CFG_W > OCC_W) ? CFG_W : OCC_W;

    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(64);

    // opcodes
    localparam logic OP_REF   = 1'b0;
    localparam logic OP_EVICT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_VICTIM = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

endpackage

// ===== sv/lru_frame_replacement_top.sv =====
// LRU replacement stack for physical frame numbers, most recent on top.
// Input channel (i_in_valid / o_in_stall) carries an opcode and a frame
// number; output channel (o_out_valid / i_out_stall) returns one status and
// victim frame per input transfer, in order.
// The stack lives in a 64-entry synchronous RAM, one read and one write port.
// A reference walks the stack from the top one entry per cycle, shifting
// each entry down one slot as it goes, and stops on a match:
//   hit                   : the walk stops at the matching entry
//   miss                  : the walk runs past the bottom occupied entry
//   evict                 : same edge as the transfer if empty, else after a bottom read
// One item is in flight at a time: the input stalls until the current item
// has finished and its result has been registered.
// i_cfg_we writes the frame limit (0 acts as 1, above 64 acts as 64).
// Reset (i_rst_n low, synchronous) empties the stack and sets the limit to
// 64; RAM contents are not cleared, only entries below occupancy are used.
// When the receiver stalls, a finished result waits in the output register
// and a second one in a hold register; the next transfer is not taken
// until the second one has moved into the output register.
module lru_frame_replacement_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [lrufr_pkg::FRAME_W-1:0]   i_frame_number,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lrufr_pkg::STATUS_W-1:0]  o_status,
    output logic [lrufr_pkg::FRAME_W-1:0]   o_victim_frame,
    input  logic                            i_cfg_we,
    input  logic [lrufr_pkg::CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVRD,
        S_HOLD
    } t_state;

    // stack RAM
    logic [lrufr_pkg::FRAME_W-1:0] r_stack [lrufr_pkg::MAX_FRAMES];
    logic [lrufr_pkg::FRAME_W-1:0] r_rdata;
    logic [lrufr_pkg::IDX_W-1:0]   rd_addr;
    logic                          mem_we;
    logic [lrufr_pkg::IDX_W-1:0]   mem_waddr;
    logic [lrufr_pkg::FRAME_W-1:0] mem_wdata;

    t_state                         r_state, n_state;
    logic [lrufr_pkg::OCC_W-1:0]    r_occ, n_occ;
    logic [lrufr_pkg::OCC_W-1:0]    r_idx, n_idx;
    logic [lrufr_pkg::FRAME_W-1:0]  r_carry, n_carry;
    logic [lrufr_pkg::FRAME_W-1:0]  r_frame, n_frame;
    logic [lrufr_pkg::CFG_W-1:0]    r_limit;

    logic                           r_out_valid;
    logic [lrufr_pkg::STATUS_W-1:0] r_status, r_pend_status;
    logic [lrufr_pkg::FRAME_W-1:0]  r_victim, r_pend_victim;

    logic                           in_take;
    logic                           slot_free;
    logic                           done;
    logic [lrufr_pkg::STATUS_W-1:0] d_status;
    logic [lrufr_pkg::FRAME_W-1:0]  d_victim;
    logic [lrufr_pkg::OCC_W-1:0]    occ_m1;
    logic [lrufr_pkg::OCC_W-1:0]    eff_limit;
    logic [lrufr_pkg::CMP_W-1:0]    limit_ext;

    // clamp limit into 1..MAX_FRAMES
    always_comb begin
        limit_ext = lrufr_pkg::CMP_W'(r_limit);
        if (r_limit == '0) begin
            eff_limit = lrufr_pkg::OCC_W'(1);
        end else if (limit_ext > lrufr_pkg::CMP_W'(lrufr_pkg::MAX_FRAMES)) begin
            eff_limit = lrufr_pkg::OCC_W'(lrufr_pkg::MAX_FRAMES);
        end else begin
            eff_limit = lrufr_pkg::OCC_W'(limit_ext);
        end
    end

    assign occ_m1     = r_occ - lrufr_pkg::OCC_W'(1);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_carry   = r_carry;
        n_frame   = r_frame;
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_waddr = r_idx[lrufr_pkg::IDX_W-1:0];
        mem_wdata = r_carry;
        done      = 1'b0;
        d_status  = lrufr_pkg::ST_HIT;
        d_victim  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_frame = i_frame_number;
                    if (i_opcode == lrufr_pkg::OP_EVICT) begin
                        if (r_occ == '0) begin
                            done     = 1'b1;
                            d_status = lrufr_pkg::ST_EMPTY;
                        end else begin
                            rd_addr = occ_m1[lrufr_pkg::IDX_W-1:0];
                            n_state = S_EVRD;
                        end
                    end else begin
                        // carry starts as the new top; read entry 0
                        n_idx   = '0;
                        n_carry = i_frame_number;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == r_occ) begin
                    // walked past the bottom: miss
                    done = 1'b1;
                    if (r_occ >= eff_limit) begin
                        // carry holds the old bottom entry
                        d_status = lrufr_pkg::ST_VICTIM;
                        d_victim = r_carry;
                    end else begin
                        mem_we   = 1'b1;
                        d_status = lrufr_pkg::ST_INSERT;
                        n_occ    = r_occ + lrufr_pkg::OCC_W'(1);
                    end
                end else begin
                    // shift: slot gets entry above it, carry takes old entry
                    mem_we = 1'b1;
                    if (r_rdata == r_frame) begin
                        done     = 1'b1;
                        d_status = lrufr_pkg::ST_HIT;
                    end else begin
                        n_carry = r_rdata;
                        n_idx   = r_idx + lrufr_pkg::OCC_W'(1);
                        rd_addr = n_idx[lrufr_pkg::IDX_W-1:0];
                    end
                end
            end
            S_EVRD: begin
                done     = 1'b1;
                d_status = lrufr_pkg::ST_VICTIM;
                d_victim = r_rdata;
                n_occ    = occ_m1;
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (done) begin
            n_state = slot_free ? S_IDLE : S_HOLD;
        end
    end

    // RAM: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_stack[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_limit     <= lrufr_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (done && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_HOLD && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_idx   <= n_idx;
        r_carry <= n_carry;
        r_frame <= n_frame;
        if (done && slot_free) begin
            r_status <= d_status;
            r_victim <= d_victim;
        end else if (r_state == S_HOLD && slot_free) begin
            r_status <= r_pend_status;
            r_victim <= r_pend_victim;
        end
        if (done && !slot_free) begin
            r_pend_status <= d_status;
            r_pend_victim <= d_victim;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_victim_frame = r_victim;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= lrufr_pkg::OCC_W'(lrufr_pkg::MAX_FRAMES))
        else $error("occupancy above capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_occ))
        else $error("scan index past occupancy");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_occ == $past(r_occ)
            || r_occ == $past(r_occ) + lrufr_pkg::OCC_W'(1)
            || r_occ == $past(r_occ) - lrufr_pkg::OCC_W'(1)))
        else $error("occupancy moved by more than one");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != lrufr_pkg::ST_VICTIM) |-> (o_victim_frame == '0))
        else $error("victim frame set without eviction");
`endif

endmodule

// ===== dv/tb_lru_frame_replacement_top.sv =====
module tb_lru_frame_replacement_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Run bounds. The slowest reference walks a full stack, and random stalls
    // on both sides lengthen each transfer further.
    localparam int unsigned RUN_LIMIT   = 1_000_000;
    localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int          TAIL_CYCLES = 100;   // > worst-case walk latency
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [lrufr_pkg::STATUS_W-1:0] status;
        logic [lrufr_pkg::FRAME_W-1:0]  victim;
    } t_lru_outcome;

    // DUT pins
    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_in_valid     = 1'b0;
    logic                           o_in_stall;
    logic                           i_opcode       = lrufr_pkg::OP_REF;
    logic [lrufr_pkg::FRAME_W-1:0]  i_frame_number = '0;
    logic                           o_out_valid;
    logic                           i_out_stall    = 1'b0;
    logic [lrufr_pkg::STATUS_W-1:0] o_status;
    logic [lrufr_pkg::FRAME_W-1:0]  o_victim_frame;
    logic                           i_cfg_we       = 1'b0;
    logic [lrufr_pkg::CFG_W-1:0]    i_cfg_data     = '0;

    // Shadow copy of the recency stack, top at index 0.
    logic [lrufr_pkg::FRAME_W-1:0]  shadow_stack [lrufr_pkg::MAX_FRAMES];
    int                             shadow_occ   = 0;
    logic [lrufr_pkg::CFG_W-1:0]    shadow_limit = lrufr_pkg::LIMIT_RESET;

    // Outcomes predicted at each input transfer, oldest first.
    t_lru_outcome        outcome_q [$];

    int                  err_count      = 0;
    int unsigned         cycle_count    = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_req       = 0;   // bumped by the test to ask for a hold-off
    int                  hold_seen      = 0;
    int                  hold_left      = 0;

    lru_frame_replacement_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_frame_number (i_frame_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_victim_frame (o_victim_frame),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("lru_frame_replacement_top: mismatch");
            $finish;
        end
    end

    function automatic void report_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    // Slide entries [0, count) down one slot and put frame on top.
    function automatic void push_on_top(int count, logic [lrufr_pkg::FRAME_W-1:0] frame);
        int i;
        for (i = count; i > 0; i--) begin
            if (i < lrufr_pkg::MAX_FRAMES) begin
                shadow_stack[i] = shadow_stack[i-1];
            end
        end
        shadow_stack[0] = frame;
    endfunction

    // Next outcome of the LRU stack for one accepted transfer; updates the shadow.
    function automatic t_lru_outcome lru_predict(logic op,
                                                 logic [lrufr_pkg::FRAME_W-1:0] frame);
        t_lru_outcome res;
        int           lim;
        int           pos;
        int           i;
        res.status = lrufr_pkg::ST_HIT;
        res.victim = '0;
        pos        = -1;
        // 0 acts as 1, anything above the capacity acts as the capacity
        lim = (shadow_limit == 0) ? 1 : int'(shadow_limit);
        if (lim > lrufr_pkg::MAX_FRAMES) begin
            lim = lrufr_pkg::MAX_FRAMES;
        end
        if (op == lrufr_pkg::OP_EVICT) begin
            if (shadow_occ == 0) begin
                res.status = lrufr_pkg::ST_EMPTY;   // nothing to drop, state untouched
            end else begin
                res.victim = shadow_stack[shadow_occ-1];
                shadow_occ--;
                res.status = lrufr_pkg::ST_VICTIM;
            end
        end else begin
            for (i = 0; i < shadow_occ; i++) begin
                if (pos < 0 && shadow_stack[i] == frame) begin
                    pos = i;
                end
            end
            if (pos >= 0) begin
                push_on_top(pos, frame);
                res.status = lrufr_pkg::ST_HIT;
            end else if (shadow_occ >= lim) begin
                // full (or limit lowered below occupancy): drop bottom, occupancy holds
                res.victim = shadow_stack[shadow_occ-1];
                push_on_top(shadow_occ - 1, frame);
                res.status = lrufr_pkg::ST_VICTIM;
            end else begin
                push_on_top(shadow_occ, frame);
                shadow_occ++;
                res.status = lrufr_pkg::ST_INSERT;
            end
        end
        return res;
    endfunction

    // Receiver: random stall at the configured rate, or a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker: every output transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_lru_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                report_error($sformatf("unexpected result: status %0d victim %0d",
                                       o_status, o_victim_frame));
            end else begin
                want = outcome_q.pop_front();
                if (want.status !== o_status || want.victim !== o_victim_frame) begin
                    report_error($sformatf("status exp %0d got %0d, victim exp %0d got %0d",
                                           want.status, o_status, want.victim,
                                           o_victim_frame));
                end
            end
        end
    end

    // One input transfer. Valid is left high on return; the next call either
    // replaces the payload or drops valid at the following falling edge.
    task automatic send_item(logic op, logic [lrufr_pkg::FRAME_W-1:0] frame);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_frame_number <= frame;
        do @(posedge i_clk); while (o_in_stall);
        outcome_q.push_back(lru_predict(op, frame));
    endtask

    // Stop offering and wait until every predicted result has been seen.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outcome_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Frame limit write, only with the block idle.
    task automatic write_limit(logic [lrufr_pkg::CFG_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        shadow_limit = value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [lrufr_pkg::CFG_W-1:0] pick_limit();
        case ($urandom_range(7))
            0:       return '0;
            1:       return lrufr_pkg::CFG_W'(1);
            2:       return lrufr_pkg::CFG_W'(2);
            3:       return lrufr_pkg::CFG_W'($urandom_range(16, 3));
            4:       return lrufr_pkg::CFG_W'($urandom_range(63, 17));
            5:       return lrufr_pkg::CFG_W'(lrufr_pkg::MAX_FRAMES);
            6:       return lrufr_pkg::CFG_W'($urandom_range(126, 65));
            default: return lrufr_pkg::CFG_W'(127);
        endcase
    endfunction

    // Walks every status: empty evict, insert, hit on top and deeper, eviction
    // of the sole entry, limit 0, limit above capacity, limit lowered under
    // the current occupancy.
    task automatic test_directed();
        send_item(lrufr_pkg::OP_EVICT, 6'd0);     // empty stack
        send_item(lrufr_pkg::OP_REF,   6'd0);
        send_item(lrufr_pkg::OP_REF,   6'd63);
        send_item(lrufr_pkg::OP_REF,   6'd63);    // hit on top entry
        send_item(lrufr_pkg::OP_REF,   6'd0);     // hit one deep
        send_item(lrufr_pkg::OP_REF,   6'd42);
        send_item(lrufr_pkg::OP_EVICT, 6'd63);    // frame ignored on evict
        send_item(lrufr_pkg::OP_EVICT, 6'd0);
        send_item(lrufr_pkg::OP_EVICT, 6'd21);    // last entry leaves
        send_item(lrufr_pkg::OP_EVICT, 6'd0);
        write_limit('0);                          // acts as one
        send_item(lrufr_pkg::OP_REF,   6'd21);
        send_item(lrufr_pkg::OP_REF,   6'd42);    // miss on full stack of one
        send_item(lrufr_pkg::OP_REF,   6'd42);
        send_item(lrufr_pkg::OP_EVICT, 6'd0);
        write_limit(lrufr_pkg::CFG_W'(127));      // clipped to capacity
        send_item(lrufr_pkg::OP_REF,   6'd1);
        send_item(lrufr_pkg::OP_REF,   6'd2);
        send_item(lrufr_pkg::OP_REF,   6'd4);
        send_item(lrufr_pkg::OP_REF,   6'd8);
        write_limit(lrufr_pkg::CFG_W'(2));        // now below occupancy
        send_item(lrufr_pkg::OP_REF,   6'd16);
        send_item(lrufr_pkg::OP_REF,   6'd4);
        send_item(lrufr_pkg::OP_REF,   6'd32);
        repeat (5) send_item(lrufr_pkg::OP_EVICT, 6'd0);   // drain, then one on empty
    endtask

    // Random traffic, mostly drawn from a working set about the size of the
    // limit so hits, misses and victims all show up; the rest is noise.
    task automatic test_random_traffic(int n_items);
        int                            k;
        int                            lim;
        int                            ws_size;
        int                            ws_base;
        int                            roll;
        logic [lrufr_pkg::FRAME_W-1:0] frame;
        ws_size = 4;
        ws_base = 0;
        for (k = 0; k < n_items; k++) begin
            if (k % 45 == 0) begin
                write_limit(pick_limit());
                lim = (shadow_limit == 0) ? 1 : int'(shadow_limit);
                if (lim > lrufr_pkg::MAX_FRAMES) begin
                    lim = lrufr_pkg::MAX_FRAMES;
                end
                ws_size = lim + $urandom_range(2);
                if (ws_size > lrufr_pkg::MAX_FRAMES) begin
                    ws_size = lrufr_pkg::MAX_FRAMES;
                end
                ws_base = $urandom_range(lrufr_pkg::MAX_FRAMES - 1);
            end
            roll = $urandom_range(99);
            if (roll < 12) begin
                send_item(lrufr_pkg::OP_EVICT, lrufr_pkg::FRAME_W'($urandom_range(63)));
            end else begin
                if (roll < 75) begin
                    frame = lrufr_pkg::FRAME_W'(ws_base + $urandom_range(ws_size - 1));
                end else begin
                    frame = lrufr_pkg::FRAME_W'($urandom_range(63));
                end
                send_item(lrufr_pkg::OP_REF, frame);
            end
        end
    endtask

    // Receiver holds off long enough for the block to back up and stall its
    // input; later the sender pauses until everything has come back.
    task automatic test_backpressure();
        int k;
        write_limit(lrufr_pkg::CFG_W'(8));
        hold_req++;
        for (k = 0; k < 30; k++) begin
            send_item(($urandom_range(9) == 0) ? lrufr_pkg::OP_EVICT : lrufr_pkg::OP_REF,
                      lrufr_pkg::FRAME_W'($urandom_range(11)));
        end
        wait_drained();
        for (k = 0; k < 30; k++) begin
            send_item(($urandom_range(9) == 0) ? lrufr_pkg::OP_EVICT : lrufr_pkg::OP_REF,
                      lrufr_pkg::FRAME_W'($urandom_range(11)));
        end
    endtask

    initial begin
        shadow_occ   = 0;
        shadow_limit = lrufr_pkg::LIMIT_RESET;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles more rarely than the receiver stalls
        send_idle_pct  = 29;
        recv_stall_pct = 53;
        test_directed();
        test_random_traffic(180);

        // and the other way round
        send_idle_pct  = 53;
        recv_stall_pct = 29;
        test_random_traffic(180);

        // back to back on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(180);
        test_backpressure();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", outcome_q.size()));
        end

        if (err_count == 0) begin
            $display("lru_frame_replacement_top: match");
        end else begin
            $display("lru_frame_replacement_top: mismatch");
        end
        $finish;
    end

endmodule
